[hw/rtl/rcch_pkg.sv]
// rcch_pkg: types, constants and helpers for the ray/circle closest-hit block.
// Used by ray_circle_closest_hit; no dependencies.
`default_nettype none

package rcch_pkg;

    localparam int SQ_STEPS = 50;           // root bits of the 100-bit radicand
    localparam int ROOT_DIV_STEPS = 31;     // quotient bits of a root distance
    localparam int NORM_DIV_STEPS = 15;     // quotient bits of a normal component

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [15:0] MIN_LAMBDA_RST = 16'd66;
    localparam logic [31:0] ROOT_FAR = 32'h8000_0000;

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE, S_A0, S_A1, S_RD, S_LOAD, S_B0, S_B1, S_FF0, S_FF1,
        S_RR, S_BB0, S_BB1, S_BB2, S_DIFF, S_AC0, S_AC1, S_DISC, S_SQRT, S_LM,
        S_DIVM, S_LP, S_DIVP, S_PICK, S_NEXT, S_HX, S_HY, S_V, S_VX, S_VY,
        S_SQRT2, S_NX, S_DIVX, S_NY, S_DIVY, S_OUT
    } state_t;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]        radius;
        logic [1:0]         kind;
        logic [15:0]        rindex;
    } entry_t;

    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        logic signed [15:0] n;
        n = -v;
        return v[15] ? n : v;
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        logic signed [32:0] n;
        n = -v;
        return v[32] ? n : v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -35'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ray_circle_closest_hit.sv]
// ray_circle_closest_hit: circle table with a sequenced closest-hit ray query.
// Depends on rcch_pkg (state, table entry type, helpers).
`default_nettype none

// Usage
//   s_t* carries requests. tuser = command (0 write slot, 1 query).
//   A write loads one circle slot and returns nothing.
//   A query with a nonzero direction walks every slot through one shared
//   33x33 multiplier, a bit-serial square root and a restoring divider,
//   then builds hit point and normal; s_tready is low for the whole query.
//   m_t* carries one result per query from an output register; the next
//   request is taken while a result waits, only the final load stalls on
//   m_tready.
//   cfg_we/cfg_wdata write min_lambda (reset 66).
//   After reset a clearing pass over every slot empties the table;
//   s_tready stays low meanwhile.
module ray_circle_closest_hit #(
    parameter int NUM_CIRCLES = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // slot, pos_x, pos_y, dir_x, dir_y, radius, present, material,
    // refr_index, lambda_limit
    input  wire logic [183:0] s_tdata,
    // command
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // hit_lambda, hit_x, hit_y, normal_x, normal_y, hit_material, hit_refr_index
    output logic [151:0]      m_tdata,
    // hit
    output logic              m_tuser,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata
);

    localparam int IDX_W = (NUM_CIRCLES > 1) ? $clog2(NUM_CIRCLES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CIRCLES - 1);

    // request fields
    logic               in_cmd;
    logic [4:0]         in_slot;
    logic signed [31:0] in_pos_x, in_pos_y;
    logic signed [15:0] in_dir_x, in_dir_y;
    logic [30:0]        in_radius, in_limit;
    logic               in_present;
    logic [1:0]         in_material;
    logic [15:0]        in_refr;

    assign in_cmd      = s_tuser;
    assign in_slot     = s_tdata[4:0];
    assign in_pos_x    = s_tdata[36:5];
    assign in_pos_y    = s_tdata[68:37];
    assign in_dir_x    = s_tdata[84:69];
    assign in_dir_y    = s_tdata[100:85];
    assign in_radius   = s_tdata[131:101];
    assign in_present  = s_tdata[132];
    assign in_material = s_tdata[134:133];
    assign in_refr     = s_tdata[150:135];
    assign in_limit    = s_tdata[181:151];

    // control
    rcch_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]      minl_reg, minl_next;
    logic             mvalid_reg, mvalid_next;

    // datapath
    logic signed [31:0] ox_reg, ox_next, oy_reg, oy_next;
    logic signed [15:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [30:0]        best_reg, best_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   fidx_reg, fidx_next;
    logic [31:0]        a_reg, a_next;
    logic signed [32:0] fx_reg, fx_next, fy_reg, fy_next;
    logic signed [50:0] b_reg, b_next;
    logic [65:0]        ff_reg, ff_next;
    logic [61:0]        rr_reg, rr_next;
    logic [99:0]        bb_reg, bb_next;
    logic [65:0]        dd_reg, dd_next;
    logic               le_reg, le_next;
    logic [99:0]        ac_reg, ac_next;
    logic [99:0]        rad_reg, rad_next;
    logic [51:0]        srem_reg, srem_next;
    logic [49:0]        sroot_reg, sroot_next;
    logic [5:0]         scnt_reg, scnt_next;
    logic [31:0]        lm_reg, lm_next, lp_reg, lp_next;
    logic [63:0]        drem_reg, drem_next, dsh_reg, dsh_next;
    logic [30:0]        q_reg, q_next;
    logic [4:0]         dcnt_reg, dcnt_next;
    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic signed [32:0] vx_reg, vx_next, vy_reg, vy_next;
    logic [33:0]        len_reg, len_next;
    logic signed [15:0] nx_reg, nx_next, ny_reg, ny_next;

    // result register
    logic               ohit_reg, ohit_next;
    logic [30:0]        olam_reg, olam_next;
    logic signed [31:0] ox_out_reg, ox_out_next, oy_out_reg, oy_out_next;
    logic signed [15:0] onx_reg, onx_next, ony_reg, ony_next;
    logic [1:0]         omat_reg, omat_next;
    logic [15:0]        ori_reg, ori_next;

    // table
    rcch_pkg::entry_t mem [NUM_CIRCLES];
    rcch_pkg::entry_t mem_q, mem_wdata;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_q <= mem[idx_reg];
    end

    // shared multiplier and iterative steps
    logic [32:0] mul_a, mul_b;
    logic [65:0] prod;
    logic [15:0] dxm, dym;
    logic [32:0] fxm, fym, vxm, vym;
    logic signed [50:0] b_neg;
    logic [49:0] bm;
    logic [31:0] a_sum;
    logic [53:0] sq_rem2, sq_trial;
    logic        sq_ge;
    logic        dv_ge;
    logic [30:0] q_step;
    logic signed [52:0] num_m, num_p;
    logic [51:0] a_sh17;
    logic        lm_zero, lm_far, lp_zero, lp_far;
    logic [31:0] t_sel;
    logic        pick_ok, closer;
    logic signed [47:0] hp_s;
    logic signed [34:0] hp_sum;
    logic [15:0] nq;
    logic        accept, wr_ok;

    assign dxm   = rcch_pkg::mag16(dx_reg);
    assign dym   = rcch_pkg::mag16(dy_reg);
    assign fxm   = rcch_pkg::mag33(fx_reg);
    assign fym   = rcch_pkg::mag33(fy_reg);
    assign vxm   = rcch_pkg::mag33(vx_reg);
    assign vym   = rcch_pkg::mag33(vy_reg);
    assign b_neg = -b_reg;
    assign bm    = b_reg[50] ? b_neg[49:0] : b_reg[49:0];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            rcch_pkg::S_A0:  begin mul_a = 33'(dxm);          mul_b = 33'(dxm); end
            rcch_pkg::S_A1:  begin mul_a = 33'(dym);          mul_b = 33'(dym); end
            rcch_pkg::S_B0:  begin mul_a = 33'(dxm);          mul_b = fxm; end
            rcch_pkg::S_B1:  begin mul_a = 33'(dym);          mul_b = fym; end
            rcch_pkg::S_FF0: begin mul_a = fxm;               mul_b = fxm; end
            rcch_pkg::S_FF1: begin mul_a = fym;               mul_b = fym; end
            rcch_pkg::S_RR:  begin mul_a = 33'(mem_q.radius); mul_b = 33'(mem_q.radius); end
            rcch_pkg::S_BB0: begin mul_a = bm[32:0];          mul_b = bm[32:0]; end
            rcch_pkg::S_BB1: begin mul_a = bm[32:0];          mul_b = 33'(bm[49:33]); end
            rcch_pkg::S_BB2: begin mul_a = 33'(bm[49:33]);    mul_b = 33'(bm[49:33]); end
            rcch_pkg::S_AC0: begin mul_a = dd_reg[32:0];      mul_b = 33'(a_reg); end
            rcch_pkg::S_AC1: begin mul_a = dd_reg[65:33];     mul_b = 33'(a_reg); end
            rcch_pkg::S_HX:  begin mul_a = 33'(best_reg);     mul_b = 33'(dxm); end
            rcch_pkg::S_HY:  begin mul_a = 33'(best_reg);     mul_b = 33'(dym); end
            rcch_pkg::S_VX:  begin mul_a = vxm;               mul_b = vxm; end
            rcch_pkg::S_VY:  begin mul_a = vym;               mul_b = vym; end
            default:         begin mul_a = '0;                mul_b = '0; end
        endcase
    end

    assign prod  = mul_a * mul_b;
    assign a_sum = a_reg + prod[31:0];

    assign sq_rem2  = {srem_reg, rad_reg[99:98]};
    assign sq_trial = {2'b00, sroot_reg, 2'b01};
    assign sq_ge    = sq_rem2 >= sq_trial;

    assign dv_ge  = drem_reg >= dsh_reg;
    assign q_step = {q_reg[29:0], dv_ge};

    assign num_m   = -53'(b_reg) - $signed({3'b000, sroot_reg});
    assign num_p   = -53'(b_reg) + $signed({3'b000, sroot_reg});
    assign a_sh17  = {3'b000, a_reg, 17'd0};
    assign lm_zero = num_m[52] || (num_m == '0);
    assign lm_far  = num_m[51:0] >= a_sh17;
    assign lp_zero = num_p[52] || (num_p == '0);
    assign lp_far  = num_p[51:0] >= a_sh17;

    assign t_sel   = (lm_reg > {16'd0, minl_reg}) ? lm_reg : lp_reg;
    assign pick_ok = (lm_reg > {16'd0, minl_reg}) || (lp_reg > {16'd0, minl_reg});
    assign closer  = t_sel < {1'b0, best_reg};

    always_comb
    begin
        hp_s = $signed({2'b00, prod[45:0]});
        if ((state_reg == rcch_pkg::S_HX) ? dx_reg[15] : dy_reg[15])
            hp_s = -$signed({2'b00, prod[45:0]});
        hp_sum = 35'((state_reg == rcch_pkg::S_HX) ? ox_reg : oy_reg)
               + 35'($signed(hp_s[47:14]));
    end

    assign nq     = {1'b0, q_step[14:0]};
    assign accept = s_tvalid && s_tready;
    assign wr_ok  = {27'd0, in_slot} < 32'(NUM_CIRCLES);

    assign s_tready = (state_reg == rcch_pkg::S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tuser  = ohit_reg;
    assign m_tdata  = {7'd0, ori_reg, omat_reg, ony_reg, onx_reg, oy_out_reg, ox_out_reg,
                       olam_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rcch_pkg::S_CLEAR: if (idx_reg == LAST_IDX) state_next = rcch_pkg::S_IDLE;
            rcch_pkg::S_IDLE:
                if (accept && in_cmd == rcch_pkg::CMD_QUERY)
                    state_next = rcch_pkg::S_A0;
            rcch_pkg::S_A0:  state_next = rcch_pkg::S_A1;
            rcch_pkg::S_A1:  state_next = (a_sum == '0) ? rcch_pkg::S_OUT : rcch_pkg::S_RD;
            rcch_pkg::S_RD:  state_next = rcch_pkg::S_LOAD;
            rcch_pkg::S_LOAD: state_next = mem_q.valid ? rcch_pkg::S_B0 : rcch_pkg::S_NEXT;
            rcch_pkg::S_B0:  state_next = rcch_pkg::S_B1;
            rcch_pkg::S_B1:  state_next = rcch_pkg::S_FF0;
            rcch_pkg::S_FF0: state_next = rcch_pkg::S_FF1;
            rcch_pkg::S_FF1: state_next = rcch_pkg::S_RR;
            rcch_pkg::S_RR:  state_next = rcch_pkg::S_BB0;
            rcch_pkg::S_BB0: state_next = rcch_pkg::S_BB1;
            rcch_pkg::S_BB1: state_next = rcch_pkg::S_BB2;
            rcch_pkg::S_BB2: state_next = rcch_pkg::S_DIFF;
            rcch_pkg::S_DIFF: state_next = rcch_pkg::S_AC0;
            rcch_pkg::S_AC0: state_next = rcch_pkg::S_AC1;
            rcch_pkg::S_AC1: state_next = rcch_pkg::S_DISC;
            rcch_pkg::S_DISC:
                state_next = (!le_reg && ac_reg > bb_reg) ? rcch_pkg::S_NEXT
                                                          : rcch_pkg::S_SQRT;
            rcch_pkg::S_SQRT: if (scnt_reg == 6'd1) state_next = rcch_pkg::S_LM;
            rcch_pkg::S_LM:
                state_next = (lm_zero || lm_far) ? rcch_pkg::S_LP : rcch_pkg::S_DIVM;
            rcch_pkg::S_DIVM: if (dcnt_reg == 5'd1) state_next = rcch_pkg::S_LP;
            rcch_pkg::S_LP:
                state_next = (lp_zero || lp_far) ? rcch_pkg::S_PICK : rcch_pkg::S_DIVP;
            rcch_pkg::S_DIVP: if (dcnt_reg == 5'd1) state_next = rcch_pkg::S_PICK;
            rcch_pkg::S_PICK: state_next = rcch_pkg::S_NEXT;
            rcch_pkg::S_NEXT:
                priority if (idx_reg != LAST_IDX)
                    state_next = rcch_pkg::S_RD;
                else if (found_reg)
                    state_next = rcch_pkg::S_HX;
                else
                    state_next = rcch_pkg::S_OUT;
            rcch_pkg::S_HX:  state_next = rcch_pkg::S_HY;
            rcch_pkg::S_HY:  state_next = rcch_pkg::S_V;
            rcch_pkg::S_V:   state_next = rcch_pkg::S_VX;
            rcch_pkg::S_VX:  state_next = rcch_pkg::S_VY;
            rcch_pkg::S_VY:  state_next = rcch_pkg::S_SQRT2;
            rcch_pkg::S_SQRT2: if (scnt_reg == 6'd1) state_next = rcch_pkg::S_NX;
            rcch_pkg::S_NX:
                state_next = (sroot_reg == '0) ? rcch_pkg::S_OUT : rcch_pkg::S_DIVX;
            rcch_pkg::S_DIVX: if (dcnt_reg == 5'd1) state_next = rcch_pkg::S_NY;
            rcch_pkg::S_NY:  state_next = rcch_pkg::S_DIVY;
            rcch_pkg::S_DIVY: if (dcnt_reg == 5'd1) state_next = rcch_pkg::S_OUT;
            rcch_pkg::S_OUT: if (!mvalid_reg || m_tready) state_next = rcch_pkg::S_IDLE;
            default: state_next = rcch_pkg::S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        idx_next = idx_reg;      minl_next = minl_reg;
        mvalid_next = mvalid_reg;
        ox_next = ox_reg;  oy_next = oy_reg;  dx_next = dx_reg;  dy_next = dy_reg;
        best_next = best_reg;  found_next = found_reg;  fidx_next = fidx_reg;
        a_next = a_reg;  fx_next = fx_reg;  fy_next = fy_reg;  b_next = b_reg;
        ff_next = ff_reg;  rr_next = rr_reg;  bb_next = bb_reg;  dd_next = dd_reg;
        le_next = le_reg;  ac_next = ac_reg;  rad_next = rad_reg;
        srem_next = srem_reg;  sroot_next = sroot_reg;  scnt_next = scnt_reg;
        lm_next = lm_reg;  lp_next = lp_reg;  drem_next = drem_reg;
        dsh_next = dsh_reg;  q_next = q_reg;  dcnt_next = dcnt_reg;
        px_next = px_reg;  py_next = py_reg;  vx_next = vx_reg;  vy_next = vy_reg;
        len_next = len_reg;  nx_next = nx_reg;  ny_next = ny_reg;
        ohit_next = ohit_reg;  olam_next = olam_reg;
        ox_out_next = ox_out_reg;  oy_out_next = oy_out_reg;
        onx_next = onx_reg;  ony_next = ony_reg;  omat_next = omat_reg;
        ori_next = ori_reg;
        mem_we = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = '0;

        if (cfg_we)
            minl_next = cfg_wdata;
        if (mvalid_reg && m_tready)
            mvalid_next = 1'b0;

        if (state_reg == rcch_pkg::S_SQRT || state_reg == rcch_pkg::S_SQRT2)
        begin
            srem_next  = sq_ge ? 52'(sq_rem2 - sq_trial) : sq_rem2[51:0];
            sroot_next = {sroot_reg[48:0], sq_ge};
            rad_next   = {rad_reg[97:0], 2'b00};
            scnt_next  = scnt_reg - 6'd1;
        end

        if (state_reg == rcch_pkg::S_DIVM || state_reg == rcch_pkg::S_DIVP
            || state_reg == rcch_pkg::S_DIVX || state_reg == rcch_pkg::S_DIVY)
        begin
            if (dv_ge)
                drem_next = drem_reg - dsh_reg;
            dsh_next  = {1'b0, dsh_reg[63:1]};
            q_next    = q_step;
            dcnt_next = dcnt_reg - 5'd1;
        end

        unique case (state_reg)
            rcch_pkg::S_CLEAR:
            begin
                mem_we = 1'b1;
                idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
            end
            rcch_pkg::S_IDLE:
                if (accept)
                begin
                    if (in_cmd == rcch_pkg::CMD_WRITE)
                    begin
                        mem_we = wr_ok;
                        mem_waddr = IDX_W'(in_slot);
                        mem_wdata.valid  = in_present;
                        mem_wdata.cx     = in_pos_x;
                        mem_wdata.cy     = in_pos_y;
                        mem_wdata.radius = in_radius;
                        mem_wdata.kind   = in_material;
                        mem_wdata.rindex = in_refr;
                    end
                    else
                    begin
                        ox_next = in_pos_x;  oy_next = in_pos_y;
                        dx_next = in_dir_x;  dy_next = in_dir_y;
                        best_next = in_limit;
                        found_next = 1'b0;
                        idx_next = '0;
                    end
                end
            rcch_pkg::S_A0:  a_next = prod[31:0];
            rcch_pkg::S_A1:  a_next = a_sum;
            rcch_pkg::S_LOAD:
            begin
                fx_next = 33'(ox_reg) - 33'(mem_q.cx);
                fy_next = 33'(oy_reg) - 33'(mem_q.cy);
            end
            rcch_pkg::S_B0:
                b_next = (dx_reg[15] ^ fx_reg[32]) ? -$signed({1'b0, prod[49:0]})
                                                   : $signed({1'b0, prod[49:0]});
            rcch_pkg::S_B1:
                b_next = (dy_reg[15] ^ fy_reg[32]) ? b_reg - $signed({1'b0, prod[49:0]})
                                                   : b_reg + $signed({1'b0, prod[49:0]});
            rcch_pkg::S_FF0: ff_next = prod;
            rcch_pkg::S_FF1: ff_next = ff_reg + prod;
            rcch_pkg::S_RR:  rr_next = prod[61:0];
            rcch_pkg::S_BB0: bb_next = {34'd0, prod};
            rcch_pkg::S_BB1: bb_next = bb_reg + {prod, 34'd0};
            rcch_pkg::S_BB2: bb_next = bb_reg + {prod[33:0], 66'd0};
            rcch_pkg::S_DIFF:
            begin
                le_next = ff_reg <= {4'd0, rr_reg};
                dd_next = (ff_reg <= {4'd0, rr_reg}) ? {4'd0, rr_reg} - ff_reg
                                                     : ff_reg - {4'd0, rr_reg};
            end
            rcch_pkg::S_AC0: ac_next = {34'd0, prod};
            rcch_pkg::S_AC1: ac_next = ac_reg + {1'b0, prod, 33'd0};
            rcch_pkg::S_DISC:
            begin
                rad_next   = le_reg ? bb_reg + ac_reg : bb_reg - ac_reg;
                srem_next  = '0;
                sroot_next = '0;
                scnt_next  = 6'(rcch_pkg::SQ_STEPS);
            end
            rcch_pkg::S_LM:
            begin
                lm_next   = lm_zero ? 32'd0 : rcch_pkg::ROOT_FAR;
                drem_next = {num_m[49:0], 14'd0};
                dsh_next  = {2'b00, a_reg, 30'd0};
                q_next    = '0;
                dcnt_next = 5'(rcch_pkg::ROOT_DIV_STEPS);
            end
            rcch_pkg::S_DIVM: if (dcnt_reg == 5'd1) lm_next = {1'b0, q_step};
            rcch_pkg::S_LP:
            begin
                lp_next   = lp_zero ? 32'd0 : rcch_pkg::ROOT_FAR;
                drem_next = {num_p[49:0], 14'd0};
                dsh_next  = {2'b00, a_reg, 30'd0};
                q_next    = '0;
                dcnt_next = 5'(rcch_pkg::ROOT_DIV_STEPS);
            end
            rcch_pkg::S_DIVP: if (dcnt_reg == 5'd1) lp_next = {1'b0, q_step};
            rcch_pkg::S_PICK:
                if (pick_ok && closer)
                begin
                    best_next  = t_sel[30:0];
                    found_next = 1'b1;
                    fidx_next  = idx_reg;
                end
            rcch_pkg::S_NEXT:
                if (idx_reg != LAST_IDX)
                    idx_next = idx_reg + 1'b1;
            rcch_pkg::S_HX:
            begin
                px_next  = rcch_pkg::sat32(hp_sum);
                idx_next = fidx_reg;
            end
            rcch_pkg::S_HY:  py_next = rcch_pkg::sat32(hp_sum);
            rcch_pkg::S_V:
            begin
                vx_next = 33'(px_reg) - 33'(mem_q.cx);
                vy_next = 33'(py_reg) - 33'(mem_q.cy);
            end
            rcch_pkg::S_VX:  ff_next = prod;
            rcch_pkg::S_VY:
            begin
                rad_next   = {34'd0, ff_reg + prod};
                srem_next  = '0;
                sroot_next = '0;
                scnt_next  = 6'(rcch_pkg::SQ_STEPS);
            end
            rcch_pkg::S_NX:
            begin
                len_next  = sroot_reg[33:0];
                nx_next   = '0;
                ny_next   = '0;
                drem_next = {17'd0, vxm, 14'd0};
                dsh_next  = {16'd0, sroot_reg[33:0], 14'd0};
                q_next    = '0;
                dcnt_next = 5'(rcch_pkg::NORM_DIV_STEPS);
            end
            rcch_pkg::S_DIVX:
                if (dcnt_reg == 5'd1)
                    nx_next = vx_reg[32] ? -$signed(nq) : $signed(nq);
            rcch_pkg::S_NY:
            begin
                drem_next = {17'd0, vym, 14'd0};
                dsh_next  = {16'd0, len_reg, 14'd0};
                q_next    = '0;
                dcnt_next = 5'(rcch_pkg::NORM_DIV_STEPS);
            end
            rcch_pkg::S_DIVY:
                if (dcnt_reg == 5'd1)
                    ny_next = vy_reg[32] ? -$signed(nq) : $signed(nq);
            rcch_pkg::S_OUT:
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    ohit_next   = found_reg;
                    olam_next   = best_reg;
                    ox_out_next = found_reg ? px_reg : '0;
                    oy_out_next = found_reg ? py_reg : '0;
                    onx_next    = found_reg ? nx_reg : '0;
                    ony_next    = found_reg ? ny_reg : '0;
                    omat_next   = found_reg ? mem_q.kind : '0;
                    ori_next    = found_reg ? mem_q.rindex : '0;
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rcch_pkg::S_CLEAR;
            idx_reg    <= '0;
            minl_reg   <= rcch_pkg::MIN_LAMBDA_RST;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            minl_reg   <= minl_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ox_reg <= ox_next;  oy_reg <= oy_next;  dx_reg <= dx_next;  dy_reg <= dy_next;
        best_reg <= best_next;  found_reg <= found_next;  fidx_reg <= fidx_next;
        a_reg <= a_next;  fx_reg <= fx_next;  fy_reg <= fy_next;  b_reg <= b_next;
        ff_reg <= ff_next;  rr_reg <= rr_next;  bb_reg <= bb_next;  dd_reg <= dd_next;
        le_reg <= le_next;  ac_reg <= ac_next;  rad_reg <= rad_next;
        srem_reg <= srem_next;  sroot_reg <= sroot_next;  scnt_reg <= scnt_next;
        lm_reg <= lm_next;  lp_reg <= lp_next;  drem_reg <= drem_next;
        dsh_reg <= dsh_next;  q_reg <= q_next;  dcnt_reg <= dcnt_next;
        px_reg <= px_next;  py_reg <= py_next;  vx_reg <= vx_next;  vy_reg <= vy_next;
        len_reg <= len_next;  nx_reg <= nx_next;  ny_reg <= ny_next;
        ohit_reg <= ohit_next;  olam_reg <= olam_next;
        ox_out_reg <= ox_out_next;  oy_out_reg <= oy_out_next;
        onx_reg <= onx_next;  ony_reg <= ony_next;  omat_reg <= omat_next;
        ori_reg <= ori_next;
    end

`ifndef NO_ASSERTIONS
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rcch_pkg::S_DIVM || state_reg == rcch_pkg::S_DIVP
         || state_reg == rcch_pkg::S_DIVX || state_reg == rcch_pkg::S_DIVY)
        |-> ({1'b0, drem_reg} < {dsh_reg, 1'b0}))
        else $error("divider remainder out of range");

    a_sqrt_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rcch_pkg::S_SQRT || state_reg == rcch_pkg::S_SQRT2)
        |-> (scnt_reg != '0))
        else $error("square root step count ran out");

    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rcch_pkg::S_PICK)
        |-> (lm_reg <= rcch_pkg::ROOT_FAR && lp_reg <= rcch_pkg::ROOT_FAR))
        else $error("root distance out of range");
`endif

endmodule

`default_nettype wire
